@@ hdl/amdfs_pkg.sv @@
`default_nettype none
package amdfs_pkg;

  localparam int VERT_W        = 6;   // vertex number width
  localparam int CNT_W         = 7;   // vertex count width
  localparam int MAX_NODES_DEF = 64;
  localparam int GRP_W         = 16;  // bits examined per scan step

  localparam logic [CNT_W-1:0] VCOUNT_RST = 7'd64;

  localparam logic OP_EDGE = 1'b0;
  localparam logic OP_RUN  = 1'b1;

  typedef struct packed {
    logic              op;
    logic [VERT_W-1:0] vertex_a;
    logic [VERT_W-1:0] vertex_b;
  } in_item_t;

  typedef struct packed {
    logic [VERT_W-1:0] visited_vertex;
    logic              last;
  } out_item_t;

  // status of the neighbour scan unit
  typedef struct packed {
    logic              busy;
    logic              done;
    logic              found;
    logic [VERT_W-1:0] idx;
  } scan_res_t;

endpackage
`default_nettype wire

@@ hdl/amdfs_adj_mem.sv @@
`default_nettype none
module amdfs_adj_mem #(
  parameter  int ROWS = amdfs_pkg::MAX_NODES_DEF,
  localparam int AW   = (ROWS > 1) ? $clog2(ROWS) : 1
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    wr_en,
  input  wire logic [AW-1:0]           wr_addr,
  input  wire logic [ROWS-1:0]         wr_data,
  input  wire logic [AW-1:0]           rd_addr,
  output logic      [ROWS-1:0]         rd_data
);
  logic [ROWS-1:0] mem [ROWS];
  logic [ROWS-1:0] row_vld_r;
  logic [ROWS-1:0] rd_q_r;
  logic            rd_vld_r;

  // rows never written read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
    end else if (wr_en) begin
      row_vld_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q_r   <= mem[rd_addr];
    rd_vld_r <= row_vld_r[rd_addr];
  end

  assign rd_data = rd_vld_r ? rd_q_r : '0;

endmodule
`default_nettype wire

@@ hdl/amdfs_stack_mem.sv @@
`default_nettype none
module amdfs_stack_mem #(
  parameter  int DEPTH = amdfs_pkg::MAX_NODES_DEF,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                          clk,
  input  wire logic                          wr_en,
  input  wire logic [AW-1:0]                 wr_addr,
  input  wire logic [amdfs_pkg::VERT_W-1:0]  wr_data,
  input  wire logic                          rd_en,
  input  wire logic [AW-1:0]                 rd_addr,
  output logic      [amdfs_pkg::VERT_W-1:0]  rd_data
);
  logic [amdfs_pkg::VERT_W-1:0] mem [DEPTH];
  logic [amdfs_pkg::VERT_W-1:0] rd_q_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_q_r;

endmodule
`default_nettype wire

@@ hdl/amdfs_scan.sv @@
`default_nettype none
module amdfs_scan #(
  parameter int WORD_W = amdfs_pkg::MAX_NODES_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [WORD_W-1:0] word,
  output amdfs_pkg::scan_res_t   res
);
  localparam int GW_BITS = amdfs_pkg::GRP_W;
  localparam int NG      = (WORD_W + GW_BITS - 1) / GW_BITS;
  localparam int GW      = (NG > 1) ? $clog2(NG) : 1;
  localparam int FW      = $clog2(GW_BITS);
  localparam int PW      = NG * GW_BITS;

  logic [PW-1:0]                word_r;
  logic [GW-1:0]                grp_r;
  logic                         busy_r;
  logic                         done_r;
  logic                         found_r;
  logic [amdfs_pkg::VERT_W-1:0] idx_r;
  logic [FW-1:0]                ffs;
  logic                         any;

  // lowest set bit of the current group
  always_comb begin
    ffs = '0;
    for (int j = GW_BITS - 1; j >= 0; j--) begin
      if (word_r[j]) begin
        ffs = FW'(j);
      end
    end
    any = |word_r[GW_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      found_r <= 1'b0;
      grp_r   <= '0;
    end else if (start) begin
      word_r  <= PW'(word);
      grp_r   <= '0;
      busy_r  <= 1'b1;
      done_r  <= 1'b0;
      found_r <= 1'b0;
    end else if (busy_r) begin
      if (any) begin
        busy_r  <= 1'b0;
        done_r  <= 1'b1;
        found_r <= 1'b1;
        idx_r   <= amdfs_pkg::VERT_W'({grp_r, ffs});
      end else if (grp_r == GW'(NG - 1)) begin
        busy_r  <= 1'b0;
        done_r  <= 1'b1;
        found_r <= 1'b0;
      end else begin
        word_r <= word_r >> GW_BITS;
        grp_r  <= grp_r + GW'(1);
      end
    end
  end

  assign res = {busy_r, done_r, found_r, idx_r};

endmodule
`default_nettype wire

@@ hdl/adjacency_matrix_dfs_order_core.sv @@
// Edge transaction: after acceptance, read row a, write a / read b, write b, then
// in_ready again; no result.
// Walk: each step reads the current row, loads the scan and runs the 16-bit scan
// in 1..MAX_NODES/16 scan steps; output stalls hold a push or the final result.
// One transaction at a time; in_ready is high only between transactions.
// Reset (rst_n, synchronous): matrix empty via row valid bits; vertex_count 64; output empty.
`default_nettype none
module adjacency_matrix_dfs_order_core #(
  parameter int MAX_NODES = amdfs_pkg::MAX_NODES_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire amdfs_pkg::in_item_t          in_data,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output amdfs_pkg::out_item_t              out_data,
  input  wire logic                         cfg_wr_en,
  input  wire logic [amdfs_pkg::CNT_W-1:0]  cfg_wr_data
);
  localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam logic [MAX_NODES-1:0] ONE = MAX_NODES'(1);
  localparam logic [amdfs_pkg::CNT_W-1:0] NODES_C = amdfs_pkg::CNT_W'(MAX_NODES);

  // Sequencer. Edge: read row a, write a / read b, write b.
  // Walk: read row of current vertex, load scan, wait for scan, then push the
  // neighbour found, pop a parent off the stack, or finish once the stack is empty.
  typedef enum logic [3:0] {
    S_IDLE,
    S_E_RD,
    S_E_WA,
    S_E_WB,
    S_W_RD,
    S_W_LD,
    S_W_SCAN,
    S_W_POP,
    S_FIN
  } state_t;

  state_t                       state_r, state_nxt;
  logic [amdfs_pkg::CNT_W-1:0]  vc_r, vc_nxt;
  logic [MAX_NODES-1:0]         visited_r, visited_nxt;
  logic [AW-1:0]                sp_r, sp_nxt;       // parents held in the stack memory
  logic [amdfs_pkg::VERT_W-1:0] cur_r, cur_nxt;     // vertex whose row is scanned
  logic [amdfs_pkg::VERT_W-1:0] pend_r, pend_nxt;   // visited, not yet emitted
  logic [amdfs_pkg::VERT_W-1:0] ea_r, ea_nxt;
  logic [amdfs_pkg::VERT_W-1:0] eb_r, eb_nxt;
  logic                         out_valid_r, out_valid_nxt;
  amdfs_pkg::out_item_t         out_data_r, out_data_nxt;

  logic                         adj_wr_en;
  logic [AW-1:0]                adj_wr_addr;
  logic [MAX_NODES-1:0]         adj_wr_data;
  logic [AW-1:0]                adj_rd_addr;
  logic [MAX_NODES-1:0]         adj_rd_data;

  logic                         stk_wr_en;
  logic                         stk_rd_en;
  logic [AW-1:0]                stk_rd_addr;
  logic [amdfs_pkg::VERT_W-1:0] stk_rd_data;

  logic                         scan_start;
  logic [MAX_NODES-1:0]         scan_word;
  amdfs_pkg::scan_res_t         scan_res;

  logic [MAX_NODES-1:0]         lim_mask;
  logic                         out_free;

  amdfs_adj_mem #(
    .ROWS (MAX_NODES)
  ) u_adj (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (adj_wr_en),
    .wr_addr (adj_wr_addr),
    .wr_data (adj_wr_data),
    .rd_addr (adj_rd_addr),
    .rd_data (adj_rd_data)
  );

  amdfs_stack_mem #(
    .DEPTH (MAX_NODES)
  ) u_stack (
    .clk     (clk),
    .wr_en   (stk_wr_en),
    .wr_addr (sp_r),
    .wr_data (cur_r),
    .rd_en   (stk_rd_en),
    .rd_addr (stk_rd_addr),
    .rd_data (stk_rd_data)
  );

  amdfs_scan #(
    .WORD_W (MAX_NODES)
  ) u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .start (scan_start),
    .word  (scan_word),
    .res   (scan_res)
  );

  // only vertices below vertex_count take part; indices beyond MAX_NODES do not exist
  always_comb begin
    for (int j = 0; j < MAX_NODES; j++) begin
      lim_mask[j] = (amdfs_pkg::CNT_W'(j) < vc_r);
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || out_ready;

  // Candidate neighbours: adjacent, unvisited and inside the count. Anything
  // adjacent below the old resume point is already visited, so no resume
  // index needs storing.
  assign scan_word = adj_rd_data & ~visited_r & lim_mask;

  always_comb begin
    state_nxt     = state_r;
    vc_nxt        = vc_r;
    visited_nxt   = visited_r;
    sp_nxt        = sp_r;
    cur_nxt       = cur_r;
    pend_nxt      = pend_r;
    ea_nxt        = ea_r;
    eb_nxt        = eb_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    adj_wr_en     = 1'b0;
    adj_wr_addr   = ea_r[AW-1:0];
    adj_wr_data   = adj_rd_data | (ONE << eb_r);
    adj_rd_addr   = cur_r[AW-1:0];
    stk_wr_en     = 1'b0;
    stk_rd_en     = 1'b0;
    stk_rd_addr   = sp_r - AW'(1);
    scan_start    = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cfg_wr_en) begin
      vc_nxt = cfg_wr_data;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_data.op == amdfs_pkg::OP_EDGE) begin
            ea_nxt = in_data.vertex_a;
            eb_nxt = in_data.vertex_b;
            // endpoints outside the matrix: transaction dropped
            if (({1'b0, in_data.vertex_a} < NODES_C) &&
                ({1'b0, in_data.vertex_b} < NODES_C)) begin
              state_nxt = S_E_RD;
            end
          end else begin
            visited_nxt = '0;
            pend_nxt    = in_data.vertex_a;
            if ({1'b0, in_data.vertex_a} >= NODES_C) begin
              // no row, no visited bit: emitted alone
              state_nxt = S_FIN;
            end else begin
              visited_nxt = ONE << in_data.vertex_a;
              cur_nxt     = in_data.vertex_a;
              sp_nxt      = '0;
              state_nxt   = S_W_RD;
            end
          end
        end
      end
      S_E_RD: begin
        adj_rd_addr = ea_r[AW-1:0];
        state_nxt   = S_E_WA;
      end
      S_E_WA: begin
        // self loop: row b read here still sees the old row, same bit either way
        adj_wr_en   = 1'b1;
        adj_wr_addr = ea_r[AW-1:0];
        adj_wr_data = adj_rd_data | (ONE << eb_r);
        adj_rd_addr = eb_r[AW-1:0];
        state_nxt   = S_E_WB;
      end
      S_E_WB: begin
        adj_wr_en   = 1'b1;
        adj_wr_addr = eb_r[AW-1:0];
        adj_wr_data = adj_rd_data | (ONE << ea_r);
        adj_rd_addr = eb_r[AW-1:0];
        state_nxt   = S_IDLE;
      end
      S_W_RD: begin
        state_nxt = S_W_LD;
      end
      S_W_LD: begin
        scan_start = 1'b1;
        state_nxt  = S_W_SCAN;
      end
      S_W_SCAN: begin
        if (scan_res.done) begin
          if (scan_res.found) begin
            // emit the previous vertex now that it is known not to be last
            if (out_free) begin
              out_valid_nxt               = 1'b1;
              out_data_nxt.visited_vertex = pend_r;
              out_data_nxt.last           = 1'b0;
              pend_nxt                    = scan_res.idx;
              visited_nxt                 = visited_r | (ONE << scan_res.idx);
              stk_wr_en                   = 1'b1;
              sp_nxt                      = sp_r + AW'(1);
              cur_nxt                     = scan_res.idx;
              state_nxt                   = S_W_RD;
            end
          end else if (sp_r == '0) begin
            state_nxt = S_FIN;
          end else begin
            stk_rd_en = 1'b1;
            sp_nxt    = sp_r - AW'(1);
            state_nxt = S_W_POP;
          end
        end
      end
      S_W_POP: begin
        cur_nxt   = stk_rd_data;
        state_nxt = S_W_RD;
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_nxt               = 1'b1;
          out_data_nxt.visited_vertex = pend_r;
          out_data_nxt.last           = 1'b1;
          state_nxt                   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vc_r        <= amdfs_pkg::VCOUNT_RST;
      visited_r   <= '0;
      sp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      vc_r        <= vc_nxt;
      visited_r   <= visited_nxt;
      sp_r        <= sp_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cur_r      <= cur_nxt;
    pend_r     <= pend_nxt;
    ea_r       <= ea_nxt;
    eb_r       <= eb_nxt;
    out_data_r <= out_data_nxt;
  end

  // a neighbour handed back by the scan is never one already visited
  a_found_unvisited: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_W_SCAN && scan_res.done && scan_res.found) |->
      ((visited_r & (ONE << scan_res.idx)) == '0))
    else $error("scan returned a visited vertex");

  // and it lies below the vertex count
  a_found_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_W_SCAN && scan_res.done && scan_res.found) |->
      ({1'b0, scan_res.idx} < vc_r))
    else $error("scan returned a vertex beyond the count");

  // the stack is empty whenever a new transaction can be taken
  a_stack_empty_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (sp_r == '0))
    else $error("stack not empty between transactions");

  // the final vertex leaves with last set and the block returns to idle
  a_fin_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && out_free) |=>
      (state_r == S_IDLE && out_valid_r && out_data_r.last))
    else $error("walk ended without a last result");

  // the sequencer never waits on a scan that is not running or finished
  a_scan_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_W_SCAN) |-> (scan_res.busy || scan_res.done))
    else $error("waiting on an idle scan unit");

endmodule
`default_nettype wire

@@ bench/adjacency_matrix_dfs_order_core_tb.sv @@
`default_nettype none
module adjacency_matrix_dfs_order_core_tb;
  import amdfs_pkg::*;

  localparam int NV           = MAX_NODES_DEF;
  localparam int HOLD_OFF     = 16;     // margin for a trailing edge transaction
  localparam int TAIL         = 200;    // quiet cycles after the last result
  localparam int DRAIN_LIMIT  = 100000; // cycles allowed for outstanding results at the end
  localparam int RANDOM_ITEMS = 240;

  // rows of the directed plan
  typedef enum logic [1:0] {ST_EDGE, ST_RUN, ST_CFG} step_kind_e;

  typedef struct packed {
    step_kind_e        kind;
    logic [VERT_W-1:0] a;
    logic [VERT_W-1:0] b;
    logic [CNT_W-1:0]  count;
    logic              solo;   // walk known to emit only its start, expectation typed in
  } plan_row_t;

  // receiver stall patterns
  typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_e;

  logic               clk         = 1'b0;
  logic               rst_n       = 1'b0;
  logic               in_valid    = 1'b0;
  logic               in_ready;
  in_item_t           in_data     = '0;
  logic               out_valid;
  logic               out_ready   = 1'b0;
  out_item_t          out_data;
  logic               cfg_wr_en   = 1'b0;
  logic [CNT_W-1:0]   cfg_wr_data = '0;

  // mirror of the block's state
  logic [NV-1:0]      adj_rows [NV];
  logic [CNT_W-1:0]   model_vcount = VCOUNT_RST;

  out_item_t          visit_q[$];   // visit order still owed by the block
  out_item_t          want_item;
  int                 errors      = 0;
  int                 mismatches  = 0;
  int                 burst_left  = 0;

  rx_mode_e           rx_mode     = RX_FREE;
  int                 rx_ctr      = 0;

  plan_row_t          plan[$];

  adjacency_matrix_dfs_order_core uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Model of the walk. Both symmetric bits are set per edge; a walk clears the
  // visited set, emits the start, then descends on the lowest unvisited
  // neighbour below the effective count, resuming each row after a return.
  // ---------------------------------------------------------------------------
  function automatic void record_edge(input logic [VERT_W-1:0] a, input logic [VERT_W-1:0] b);
    adj_rows[a][b] = 1'b1;
    adj_rows[b][a] = 1'b1;
  endfunction

  function automatic void predict_walk(input logic [VERT_W-1:0] start);
    logic [NV-1:0]     seen;
    logic [VERT_W-1:0] stk_v [NV];
    int                stk_i [NV];
    logic [VERT_W-1:0] order[$];
    logic [VERT_W-1:0] v;
    int                depth;
    int                lim;
    int                i;
    bit                found;
    out_item_t         res;
    lim   = (model_vcount < NV) ? int'(model_vcount) : NV;
    seen  = '0;
    seen[start] = 1'b1;
    order.push_back(start);
    stk_v[0] = start;
    stk_i[0] = 0;
    depth    = 1;
    while (depth > 0) begin
      v     = stk_v[depth-1];
      found = 1'b0;
      for (i = stk_i[depth-1]; i < lim; i++) begin
        if (adj_rows[v][i] && !seen[i]) begin
          stk_i[depth-1] = i + 1;
          seen[i]        = 1'b1;
          order.push_back(VERT_W'(i));
          stk_v[depth]   = VERT_W'(i);
          stk_i[depth]   = 0;
          depth++;
          found = 1'b1;
          break;
        end
      end
      if (!found) depth--;
    end
    foreach (order[k]) begin
      res.visited_vertex = order[k];
      res.last           = (k == order.size() - 1);
      visit_q.push_back(res);
    end
  endfunction

  function automatic plan_row_t mk_row(input step_kind_e kind, input int a, input int b,
                                       input int count, input bit solo);
    plan_row_t r;
    r.kind  = kind;
    r.a     = VERT_W'(a);
    r.b     = VERT_W'(b);
    r.count = CNT_W'(count);
    r.solo  = solo;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender. Called at a falling edge; returns at the falling edge after the
  // transaction is accepted, so the caller's next drive of in_valid lands in
  // that same step (either the next item or a drop).
  // ---------------------------------------------------------------------------
  task automatic offer(input logic op, input logic [VERT_W-1:0] a,
                       input logic [VERT_W-1:0] b, input bit solo);
    int        gap;
    in_item_t  item;
    out_item_t res;
    item.op       = op;
    item.vertex_a = a;
    item.vertex_b = b;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      gap = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 5);
      repeat (gap) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 6);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // accepted at this edge: update the mirror in acceptance order
    if (op == OP_EDGE) begin
      record_edge(a, b);
    end else if (solo) begin
      res.visited_vertex = a;
      res.last           = 1'b1;
      visit_q.push_back(res);
    end else begin
      predict_walk(a);
    end
    burst_left--;
    @(negedge clk);
  endtask

  // Register write only once the block is quiet: all results back, then a
  // hold-off for a trailing edge transaction.
  task automatic set_vertex_count(input logic [CNT_W-1:0] value);
    in_valid   <= 1'b0;
    burst_left = 0;
    while (visit_q.size() != 0) @(negedge clk);
    repeat (HOLD_OFF) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en    <= 1'b0;
    model_vcount = value;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: stall pattern switches between free-flowing, coin toss, mostly
  // stalled and a fixed period, each held for a random stretch.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rx_ctr == 0) begin
      rx_mode <= rx_mode_e'($urandom_range(0, 3));
      rx_ctr  <= $urandom_range(20, 300);
    end else begin
      rx_ctr <= rx_ctr - 1;
    end
    case (rx_mode)
      RX_FREE:   out_ready <= 1'b1;
      RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
      RX_SPARSE: out_ready <= ($urandom_range(0, 7) == 0);
      default:   out_ready <= rx_ctr[2];
    endcase
  end

  // ---------------------------------------------------------------------------
  // Checker: each result transaction against the oldest owed vertex.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (visit_q.size() == 0) begin
        errors++;
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: vertex %0d last %0b",
                   out_data.visited_vertex, out_data.last);
      end else begin
        want_item = visit_q.pop_front();
        if (out_data.visited_vertex !== want_item.visited_vertex ||
            out_data.last !== want_item.last) begin
          errors++;
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected vertex %0d last %0b, got vertex %0d last %0b",
                     want_item.visited_vertex, want_item.last,
                     out_data.visited_vertex, out_data.last);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    int sent;
    int phase_len;
    int lo;
    int span;
    int roll;
    int waited;
    logic [CNT_W-1:0]  vc;
    logic [VERT_W-1:0] va;
    logic [VERT_W-1:0] vb;

    for (int k = 0; k < NV; k++) adj_rows[k] = '0;

    // directed plan: empty graph after reset, extremes of the vertex range,
    // self loop, a cycle, zero / small / oversized counts, start above count
    plan.push_back(mk_row(ST_RUN,   0,  0,   0, 1'b1));  // empty matrix: start alone
    plan.push_back(mk_row(ST_RUN,  63, 63,   0, 1'b1));
    plan.push_back(mk_row(ST_EDGE,  0, 63,   0, 1'b0));
    plan.push_back(mk_row(ST_EDGE, 63, 63,   0, 1'b0));  // self loop
    plan.push_back(mk_row(ST_EDGE,  0,  1,   0, 1'b0));
    plan.push_back(mk_row(ST_EDGE,  1,  2,   0, 1'b0));
    plan.push_back(mk_row(ST_EDGE,  2,  0,   0, 1'b0));  // closes a cycle
    plan.push_back(mk_row(ST_EDGE,  1,  5,   0, 1'b0));
    plan.push_back(mk_row(ST_RUN,   0, 42,   0, 1'b0));
    plan.push_back(mk_row(ST_RUN,  63,  0,   0, 1'b0));
    plan.push_back(mk_row(ST_CFG,   0,  0,   0, 1'b0));  // zero count
    plan.push_back(mk_row(ST_RUN,   0,  0,   0, 1'b1));
    plan.push_back(mk_row(ST_RUN,  40, 21,   0, 1'b1));
    plan.push_back(mk_row(ST_CFG,   0,  0,   3, 1'b0));
    plan.push_back(mk_row(ST_RUN,   0,  0,   0, 1'b0));
    plan.push_back(mk_row(ST_RUN,   5,  0,   0, 1'b0));  // start above the count
    plan.push_back(mk_row(ST_CFG,   0,  0, 127, 1'b0));  // count above the node limit
    plan.push_back(mk_row(ST_RUN,   2, 63,   0, 1'b0));
    plan.push_back(mk_row(ST_EDGE, 62, 63,   0, 1'b0));
    plan.push_back(mk_row(ST_EDGE, 32, 31,   0, 1'b0));
    plan.push_back(mk_row(ST_CFG,   0,  0,   1, 1'b0));
    plan.push_back(mk_row(ST_RUN,   1,  0,   0, 1'b0));
    plan.push_back(mk_row(ST_CFG,   0,  0,  64, 1'b0));
    plan.push_back(mk_row(ST_RUN,  62, 32,   0, 1'b0));

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (plan[r]) begin
      case (plan[r].kind)
        ST_CFG:  set_vertex_count(plan[r].count);
        ST_EDGE: offer(OP_EDGE, plan[r].a, plan[r].b, 1'b0);
        default: offer(OP_RUN, plan[r].a, plan[r].b, plan[r].solo);
      endcase
    end

    // random phases: one count setting each, edges clustered in a window so
    // that walks go deep, a share of runs, and some fully random endpoints
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 5))
        0:       vc = '0;
        1:       vc = CNT_W'(1);
        2:       vc = CNT_W'(64);
        3:       vc = CNT_W'(127);
        4:       vc = CNT_W'($urandom_range(2, 63));
        default: vc = CNT_W'($urandom_range(65, 126));
      endcase
      set_vertex_count(vc);
      lo        = $urandom_range(0, 60);
      span      = $urandom_range(1, 63 - lo);
      phase_len = $urandom_range(12, 40);
      if (phase_len > RANDOM_ITEMS - sent) phase_len = RANDOM_ITEMS - sent;
      repeat (phase_len) begin
        roll = $urandom_range(0, 99);
        if (roll < 30) begin
          va = ($urandom_range(0, 3) == 0) ? VERT_W'($urandom_range(0, 63))
                                           : VERT_W'(lo + $urandom_range(0, span));
          vb = VERT_W'($urandom_range(0, 63));
          offer(OP_RUN, va, vb, 1'b0);
        end else if (roll < 45) begin
          va = VERT_W'($urandom_range(0, 63));
          vb = VERT_W'($urandom_range(0, 63));
          offer(OP_EDGE, va, vb, 1'b0);
        end else begin
          va = VERT_W'(lo + $urandom_range(0, span));
          vb = VERT_W'(lo + $urandom_range(0, span));
          offer(OP_EDGE, va, vb, 1'b0);
        end
        sent++;
      end
    end

    in_valid <= 1'b0;
    waited = 0;
    while (visit_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    errors += visit_q.size();
    repeat (TAIL) @(negedge clk);

    if (errors == 0) begin
      $display("adjacency_matrix_dfs_order_core_tb: PASS");
    end else begin
      $display("adjacency_matrix_dfs_order_core_tb: FAIL");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #(64'd40_000_000);
    $display("adjacency_matrix_dfs_order_core_tb: FAIL");
    $finish;
  end

endmodule
`default_nettype wire
